// File: hdl/fmsr_pkg.sv
// package for the four motor speed ramp: codes, defaults and beat types
package fmsr_pkg;

    // parameter defaults
    localparam int NUM_MOTORS_DEF  = 4;
    localparam int SPEED_LIMIT_DEF = 100;

    // step interval register reset value
    localparam logic [15:0] STEP_INTERVAL_RST = 16'd50;

    // action codes
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_FORWARD  = 3'd1;
    localparam logic [2:0] ACT_BACKWARD = 3'd2;
    localparam logic [2:0] ACT_LEFT     = 3'd3;
    localparam logic [2:0] ACT_RIGHT    = 3'd4;
    localparam logic [2:0] ACT_STOP     = 3'd5;
    localparam logic [2:0] ACT_SET      = 3'd6;

    // status codes
    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_STEP     = 2'd1;
    localparam logic [1:0] STAT_ACCEPTED = 2'd2;
    localparam logic [1:0] STAT_REJECTED = 2'd3;

    typedef struct packed {
        logic [2:0]        action;
        logic [1:0]        motor_index;
        logic signed [7:0] speed;
    } fmsr_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] motor_driven;
        logic       forward_pin;
        logic       reverse_pin;
        logic [6:0] duty;
        logic       busy_res;
    } fmsr_result_t;

endpackage

// File: hdl/fmsr_cmd_if.sv
// command channel interface: tick and motion command beats
interface fmsr_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [1:0]        motor_index;
    logic signed [7:0] speed;

    modport source (output valid, output action, output motor_index, output speed,
                    input ready);
    modport sink   (input valid, input action, input motor_index, input speed,
                    output ready);
endinterface

// File: hdl/fmsr_res_if.sv
// result channel interface: one result beat per command beat
interface fmsr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] motor_driven;
    logic       forward_pin;
    logic       reverse_pin;
    logic [6:0] duty;
    logic       busy_res;

    modport source (output valid, output status, output motor_driven,
                    output forward_pin, output reverse_pin, output duty,
                    output busy_res, input ready);
    modport sink   (input valid, input status, input motor_driven,
                    input forward_pin, input reverse_pin, input duty,
                    input busy_res, output ready);
endinterface

// File: hdl/fmsr_cfg_if.sv
// configuration write channel interface: step interval register
interface fmsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] step_interval;

    modport source (output valid, output step_interval, input ready);
    modport sink   (input valid, input step_interval, output ready);
endinterface

// File: hdl/fmsr_ramp_core.sv
// ramp state and single-pass step logic for all motors
module fmsr_ramp_core #(
    parameter int NUM_MOTORS  = fmsr_pkg::NUM_MOTORS_DEF,
    parameter int SPEED_LIMIT = fmsr_pkg::SPEED_LIMIT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  fmsr_pkg::fmsr_item_t item,
    input  logic [15:0]          step_interval,
    output fmsr_pkg::fmsr_result_t result
);
    import fmsr_pkg::*;

    localparam logic signed [7:0] POS_LIM = 8'(SPEED_LIMIT);
    localparam logic signed [7:0] NEG_LIM = 8'(-SPEED_LIMIT);

    logic signed [7:0] cur_reg  [NUM_MOTORS];
    logic signed [7:0] cur_next [NUM_MOTORS];
    logic signed [7:0] tgt_reg  [NUM_MOTORS];
    logic signed [7:0] tgt_next [NUM_MOTORS];
    logic [15:0]       icnt_reg;
    logic [15:0]       icnt_next;

    always_comb
    begin
        logic signed [7:0] s;
        logic signed [7:0] c;
        logic signed [7:0] mag;
        logic              busy_now;
        logic              found;
        logic              busy_after;

        // clamp commanded speed
        s = item.speed;
        if (s > POS_LIM)
            s = POS_LIM;
        else if (s < NEG_LIM)
            s = NEG_LIM;

        busy_now = 1'b0;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            cur_next[i] = cur_reg[i];
            tgt_next[i] = tgt_reg[i];
            if (cur_reg[i] != tgt_reg[i])
                busy_now = 1'b1;
        end

        icnt_next           = icnt_reg;
        result              = '0;
        found               = 1'b0;
        c                   = '0;
        mag                 = '0;

        unique case (item.action)
            ACT_TICK:
            begin
                if (!busy_now)
                    icnt_next = '0;
                else if (icnt_reg != '0)
                    icnt_next = icnt_reg - 16'd1;
                else
                begin
                    // lowest-index motor off target steps once
                    for (int i = 0; i < NUM_MOTORS; i++)
                    begin
                        if (!found && (cur_reg[i] != tgt_reg[i]))
                        begin
                            found = 1'b1;
                            if (cur_reg[i] < tgt_reg[i])
                                c = cur_reg[i] + 8'sd1;
                            else
                                c = cur_reg[i] - 8'sd1;
                            cur_next[i]         = c;
                            result.motor_driven = 2'(i);
                        end
                    end
                    mag                = (c < 0) ? -c : c;
                    result.status      = STAT_STEP;
                    result.forward_pin = (c > 0);
                    result.reverse_pin = (c < 0);
                    result.duty        = mag[6:0];
                    icnt_next          = (step_interval == '0) ? '0 : step_interval - 16'd1;
                end
            end
            ACT_FORWARD, ACT_BACKWARD, ACT_LEFT, ACT_RIGHT, ACT_STOP, ACT_SET:
            begin
                if (busy_now)
                    result.status = STAT_REJECTED;
                else
                begin
                    result.status = STAT_ACCEPTED;
                    icnt_next     = '0;
                    for (int i = 0; i < NUM_MOTORS; i++)
                    begin
                        unique case (item.action)
                            ACT_FORWARD:  tgt_next[i] = s;
                            ACT_BACKWARD: tgt_next[i] = -s;
                            ACT_LEFT:     tgt_next[i] = (i % 2 == 1) ? s : -s;
                            ACT_RIGHT:    tgt_next[i] = (i % 2 == 1) ? -s : s;
                            ACT_STOP:     tgt_next[i] = '0;
                            default:      tgt_next[i] = tgt_reg[i];
                        endcase
                        if ((item.action == ACT_SET) && (int'(item.motor_index) == i))
                            cur_next[i] = s;
                    end
                end
            end
            default:
            begin
                // unused action: no change
            end
        endcase

        busy_after = 1'b0;
        for (int i = 0; i < NUM_MOTORS; i++)
            if (cur_next[i] != tgt_next[i])
                busy_after = 1'b1;
        result.busy_res = busy_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
            icnt_reg <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                cur_reg[i] <= cur_next[i];
                tgt_reg[i] <= tgt_next[i];
            end
            icnt_reg <= icnt_next;
        end
    end

endmodule

// File: hdl/four_motor_speed_ramp.sv
// top level of the four motor speed ramp: input stage, ramp core, result register
//
// channel  role    beat contents
// -------  ------  ---------------------------------------------------------
// cmd      sink    action, motor_index, speed
// res      source  status, motor_driven, forward_pin, reverse_pin, duty, busy_res
// cfg      sink    step_interval (always ready)
//
// one beat in, one result beat out; a new beat can enter every cycle while res is not stalled
// path: input register, then core logic into the result register
// the input register keeps taking one beat while a result waits on res
// reset clears speeds, targets and the interval counter; step_interval resets to 50
module four_motor_speed_ramp #(
    parameter int NUM_MOTORS  = fmsr_pkg::NUM_MOTORS_DEF,
    parameter int SPEED_LIMIT = fmsr_pkg::SPEED_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fmsr_cmd_if.sink    cmd,
    fmsr_res_if.source  res,
    fmsr_cfg_if.sink    cfg
);
    import fmsr_pkg::*;

    // step interval register, writes always taken
    logic [15:0] step_interval_reg;

    // input stage
    logic       inq_valid_reg;
    logic       inq_valid_next;
    fmsr_item_t inq_item_reg;

    // result stage
    logic         res_valid_reg;
    logic         res_valid_next;
    fmsr_result_t res_data_reg;
    fmsr_result_t core_result;

    logic advance;
    logic fire;
    logic cmd_take;

    assign cfg.ready = 1'b1;

    // result register is empty or is taken this cycle
    assign advance   = !res_valid_reg || res.ready;
    // held item moves through the core into the result register
    assign fire      = inq_valid_reg && advance;
    assign cmd.ready = !inq_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        inq_valid_next = inq_valid_reg;
        if (cmd_take)
            inq_valid_next = 1'b1;
        else if (advance)
            inq_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = inq_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_interval_reg <= STEP_INTERVAL_RST;
            inq_valid_reg     <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                step_interval_reg <= cfg.step_interval;
            inq_valid_reg <= inq_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            inq_item_reg.action      <= cmd.action;
            inq_item_reg.motor_index <= cmd.motor_index;
            inq_item_reg.speed       <= cmd.speed;
        end
        if (fire)
            res_data_reg <= core_result;
    end

    fmsr_ramp_core #(
        .NUM_MOTORS  (NUM_MOTORS),
        .SPEED_LIMIT (SPEED_LIMIT)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (inq_item_reg),
        .step_interval (step_interval_reg),
        .result        (core_result)
    );

    assign res.valid        = res_valid_reg;
    assign res.status       = res_data_reg.status;
    assign res.motor_driven = res_data_reg.motor_driven;
    assign res.forward_pin  = res_data_reg.forward_pin;
    assign res.reverse_pin  = res_data_reg.reverse_pin;
    assign res.duty         = res_data_reg.duty;
    assign res.busy_res     = res_data_reg.busy_res;

endmodule

// File: tb/tb_four_motor_speed_ramp.sv
// self-checking testbench for four_motor_speed_ramp: ramp predictor checked against random motion traffic
module tb_four_motor_speed_ramp;
    import fmsr_pkg::*;

    localparam int NUM_M = NUM_MOTORS_DEF;
    localparam logic signed [7:0] SPD_MAX = 8'(SPEED_LIMIT_DEF);
    // action code left unused by the block, must be ignored
    localparam logic [2:0] ACT_NOOP = 3'd7;
    // two copies of the ramp state: one advances on accepted beats, one on queued beats
    localparam int TRACK = 0;
    localparam int PLAN  = 1;
    // length of the long result back-pressure stretch
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n;

    fmsr_cmd_if cmd_ch();
    fmsr_res_if res_ch();
    fmsr_cfg_if cfg_ch();

    four_motor_speed_ramp dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predicted ramp state, one copy per tracking point
    logic signed [7:0] cur_spd [2][NUM_M];
    logic signed [7:0] tgt_spd [2][NUM_M];
    logic [15:0]       ticks_left [2];
    logic [15:0]       step_gap [2];

    fmsr_item_t   motion_backlog [$];   // beats waiting for the driver
    fmsr_result_t predicted_drive [$];  // drive results owed by the block, oldest first

    int beats_offered = 0;
    int beats_taken   = 0;
    int cfg_writes    = 0;
    int planned_beats = 0;
    int fail_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long hold-off on the result side, started by flipping hold_req
    bit hold_req  = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    always #5 clk = ~clk;

    // commanded speed limited to plus or minus the speed limit
    function automatic logic signed [7:0] clip_speed(input logic signed [7:0] raw);
        if (raw > SPD_MAX)
            return SPD_MAX;
        if (raw < -SPD_MAX)
            return -SPD_MAX;
        return raw;
    endfunction

    // any motor still away from its target
    function automatic bit ramp_moving(input int cp);
        int m;
        for (m = 0; m < NUM_M; m++)
            if (cur_spd[cp][m] != tgt_spd[cp][m])
                return 1'b1;
        return 1'b0;
    endfunction

    // advance one copy of the ramp by one beat and return the drive result it gives
    function automatic fmsr_result_t ramp_advance(input int cp, input fmsr_item_t it);
        fmsr_result_t      r;
        logic signed [7:0] s;
        logic signed [7:0] sg;
        logic signed [7:0] c;
        logic [7:0]        mag;
        int                lead;
        int                m;
        r = '0;
        s = clip_speed(it.speed);
        if (it.action == ACT_TICK)
        begin
            if (!ramp_moving(cp))
                ticks_left[cp] = '0;
            else if (ticks_left[cp] != 16'd0)
                ticks_left[cp] = ticks_left[cp] - 16'd1;
            else
            begin
                // lowest-index motor off target takes the step
                lead = NUM_M;
                for (m = NUM_M - 1; m >= 0; m--)
                    if (cur_spd[cp][m] != tgt_spd[cp][m])
                        lead = m;
                c = cur_spd[cp][lead];
                c = (c < tgt_spd[cp][lead]) ? c + 8'sd1 : c - 8'sd1;
                cur_spd[cp][lead] = c;
                mag = (c < 0) ? -c : c;
                r.status       = STAT_STEP;
                r.motor_driven = lead[1:0];
                r.forward_pin  = (c > 0);
                r.reverse_pin  = (c < 0);
                r.duty         = mag[6:0];
                // a zero interval behaves as one
                ticks_left[cp] = (step_gap[cp] == 16'd0) ? 16'd0 : step_gap[cp] - 16'd1;
            end
        end
        else if (it.action != ACT_NOOP)
        begin
            if (ramp_moving(cp))
                r.status = STAT_REJECTED;
            else
            begin
                r.status = STAT_ACCEPTED;
                for (m = 0; m < NUM_M; m++)
                begin
                    sg = m[0] ? s : -s;
                    case (it.action)
                        ACT_FORWARD:  tgt_spd[cp][m] = s;
                        ACT_BACKWARD: tgt_spd[cp][m] = -s;
                        ACT_LEFT:     tgt_spd[cp][m] = sg;
                        ACT_RIGHT:    tgt_spd[cp][m] = -sg;
                        ACT_STOP:     tgt_spd[cp][m] = '0;
                        default:      ;
                    endcase
                end
                if (it.action == ACT_SET && it.motor_index < NUM_M)
                    cur_spd[cp][it.motor_index] = s;
                ticks_left[cp] = '0;
            end
        end
        r.busy_res = ramp_moving(cp);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // queue a beat for the driver and keep the planning copy in step with it
    task automatic queue_beat(input logic [2:0] act, input logic [1:0] midx, input logic [7:0] spd);
        fmsr_item_t it;
        it.action      = act;
        it.motor_index = midx;
        it.speed       = spd;
        motion_backlog.push_back(it);
        void'(ramp_advance(PLAN, it));
        planned_beats++;
    endtask

    // tick beat, unused fields filled with noise
    task automatic queue_tick();
        queue_beat(ACT_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    // tick until the planned ramp has reached every target
    task automatic run_out();
        while (ramp_moving(PLAN))
            queue_tick();
    endtask

    // command followed by ticks: mostly full ramps, sometimes cut short so commands bounce
    task automatic motion_bursts(input int n);
        int         goal;
        int         spd;
        logic [2:0] act;
        goal = planned_beats + n;
        while (planned_beats < goal)
        begin
            if ($urandom_range(99) < 3)
                act = ACT_NOOP;
            else
                act = 3'($urandom_range(ACT_SET, ACT_FORWARD));
            if ($urandom_range(99) < 6)
                spd = $urandom_range(255);
            else
                spd = $urandom_range(14) - 7;
            queue_beat(act, 2'($urandom_range(3)), spd[7:0]);
            if ($urandom_range(99) < 20)
                repeat ($urandom_range(6)) queue_tick();
            else
                run_out();
            repeat ($urandom_range(3)) queue_tick();
        end
        run_out();
    endtask

    // wait until every queued beat went in and every result came back
    task automatic wait_drained();
        while (motion_backlog.size() != 0 || beats_offered != beats_taken ||
               predicted_drive.size() != 0)
            @(negedge clk);
        // let the pipeline settle before touching the register
        repeat (4) @(negedge clk);
    endtask

    // write the step interval register and wait for its handshake
    task automatic write_step_gap(input logic [15:0] gap);
        int seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.step_interval <= gap;
        while (cfg_writes == seen)
            @(negedge clk);
        cfg_ch.valid <= 1'b0;
        step_gap[PLAN] = gap;
    endtask

    // command driver: holds a beat until taken, idles at random between beats
    always @(negedge clk)
    begin : cmd_driver
        fmsr_item_t next_beat;
        if (!(cmd_ch.valid && beats_offered != beats_taken))
        begin
            if (motion_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_beat = motion_backlog.pop_front();
                cmd_ch.action      <= next_beat.action;
                cmd_ch.motor_index <= next_beat.motor_index;
                cmd_ch.speed       <= next_beat.speed;
                cmd_ch.valid       <= 1'b1;
                beats_offered = beats_offered + 1;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // result side back-pressure: random stalls plus the long hold-off
    always @(negedge clk)
        res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);

    // counts the long hold-off down, one cycle at a time
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor: predicts on accepted command beats, checks result beats in order
    always @(posedge clk)
    begin : beat_monitor
        fmsr_item_t   seen_beat;
        fmsr_result_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                step_gap[TRACK] = cfg_ch.step_interval;
                cfg_writes <= cfg_writes + 1;
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen_beat.action      = cmd_ch.action;
                seen_beat.motor_index = cmd_ch.motor_index;
                seen_beat.speed       = cmd_ch.speed;
                predicted_drive.push_back(ramp_advance(TRACK, seen_beat));
                beats_taken <= beats_taken + 1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (predicted_drive.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual status %0d",
                             $time, res_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = predicted_drive.pop_front();
                    check_field("status", want.status, res_ch.status);
                    check_field("motor_driven", want.motor_driven, res_ch.motor_driven);
                    check_field("forward_pin", want.forward_pin, res_ch.forward_pin);
                    check_field("reverse_pin", want.reverse_pin, res_ch.reverse_pin);
                    check_field("duty", want.duty, res_ch.duty);
                    check_field("busy_res", want.busy_res, res_ch.busy_res);
                end
            end
        end
    end

    initial
    begin : stimulus
        int cp;
        int m;
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.action        = ACT_TICK;
        cmd_ch.motor_index   = 2'd0;
        cmd_ch.speed         = 8'sd0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.step_interval = STEP_INTERVAL_RST;
        res_ch.ready         = 1'b0;
        for (cp = 0; cp < 2; cp++)
        begin
            for (m = 0; m < NUM_M; m++)
            begin
                cur_spd[cp][m] = '0;
                tgt_spd[cp][m] = '0;
            end
            ticks_left[cp] = '0;
            step_gap[cp]   = STEP_INTERVAL_RST;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 29;
        recv_idle_pct = 81;

        // directed, interval still at its reset value
        queue_tick();                          // tick with nothing to ramp
        queue_beat(ACT_NOOP, 2'd2, 8'h09);     // unused action, ignored
        queue_beat(ACT_SET, 2'd1, 8'h02);      // motor 1 now two units off target
        queue_beat(ACT_FORWARD, 2'd0, 8'h05);  // bounced, ramp busy
        run_out();                             // step on first tick, next one after the interval
        wait_drained();

        // directed at the shortest interval: left, right, backward, stop and the speed extremes
        write_step_gap(16'd1);
        queue_beat(ACT_LEFT, 2'd3, 8'h03);
        run_out();
        queue_beat(ACT_RIGHT, 2'd0, 8'hFE);    // -2
        run_out();
        queue_beat(ACT_SET, 2'd3, 8'h7F);      // 127 clipped to the limit
        run_out();
        queue_beat(ACT_SET, 2'd0, 8'h80);      // -128 clipped to the limit
        run_out();
        queue_beat(ACT_SET, 2'd2, 8'h9B);      // -101
        run_out();
        queue_beat(ACT_BACKWARD, 2'd1, 8'h04);
        run_out();
        queue_beat(ACT_STOP, 2'd3, 8'h65);
        run_out();

        // random traffic, then a long receiver stall while the backlog is still full
        motion_bursts(140);
        hold_req = ~hold_req;
        wait_drained();

        // sender idles heavily, receiver lightly, with a full drain halfway
        send_idle_pct = 81;
        recv_idle_pct = 29;
        write_step_gap(16'd3);
        motion_bursts(90);
        wait_drained();
        motion_bursts(90);
        wait_drained();

        // no idling from here on; a zero interval steps on every tick
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_step_gap(16'd0);
        queue_beat(ACT_BACKWARD, 2'd0, 8'h80);  // -128 clipped, backward of it runs forward
        run_out();
        queue_beat(ACT_STOP, 2'd0, 8'h00);
        run_out();
        motion_bursts(70);
        queue_beat(ACT_STOP, 2'd1, 8'h00);      // park every motor before the long interval
        run_out();
        wait_drained();

        // longest interval: one step loads the full count, idle ticks clear it
        write_step_gap(16'hFFFF);
        queue_beat(ACT_SET, 2'd3, 8'h01);
        run_out();
        repeat (3) queue_tick();
        wait_drained();

        write_step_gap(16'd2);
        motion_bursts(70);
        wait_drained();

        repeat (10) @(negedge clk);
        if (fail_count == 0 && predicted_drive.size() == 0)
            $display("four_motor_speed_ramp verification clean");
        else
            $display("four_motor_speed_ramp verification failed");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin : watchdog
        #10_000_000;
        $display("four_motor_speed_ramp verification failed");
        $finish;
    end

endmodule
